### src/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int VALUE_OUT_W    = 32;
    localparam int COUNT_OUT_W    = 5;
    localparam int STATUS_W       = 2;

    typedef enum logic [1:0] {
        CMD_PUT      = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_GET      = 2'd2,
        CMD_CONTAINS = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic clear;   // clear one valid entry of the sweep
        logic load;    // capture request, restart scan
        logic scan;    // issue/compare one slot
        logic act;     // write-back or value read
        logic finish;  // load output register
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### src/key_value_table_unit.sv
// Requests: a new request is taken only after the previous one has gone through the
//   one-slot-per-cycle scan of the key memory through its single read port, plus
//   write-back and value read.
// Reset: synchronous, active low. After reset a sweep clears the slot valid memory;
//   o_stall stays high until it is done. Live count resets to zero.
`default_nettype none

module key_value_table_unit #(
    parameter int CAPACITY   = kvt_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = kvt_pkg::WORD_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // request channel
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  [1:0]                       i_command,
    input  wire  [WORD_WIDTH-1:0]            i_key,
    input  wire  [WORD_WIDTH-1:0]            i_value,
    // result channel
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic                             o_found,
    output logic [kvt_pkg::VALUE_OUT_W-1:0]  o_value_out,
    output logic [kvt_pkg::COUNT_OUT_W-1:0]  o_entry_count,
    output logic [kvt_pkg::STATUS_W-1:0]     o_status
);

    // Controller walks clear -> idle -> scan -> act -> read.
    // Scan reads one slot per cycle (key + valid), compares the registered read data,
    // and remembers the first matching slot and the lowest free slot.
    // Act does the put/delete write-back or addresses the value memory for get.
    // Read waits for room in the output register, so a new request can be
    // taken while the previous result is still stalled downstream.
    kvt_pkg::t_ctl ctl;
    kvt_pkg::t_sts sts;

    kvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_stall (o_stall)
    );

    kvt_datapath #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_value_out   (o_value_out),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

### src/kvt_ctrl.sv
`default_nettype none

module kvt_ctrl (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    input  kvt_pkg::t_sts i_sts,
    output kvt_pkg::t_ctl o_ctl,
    output logic         o_stall
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_ACT   = 5'b01000,
        S_READ  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                o_ctl.act = 1'b1;
                n_state   = S_READ;
            end
            S_READ: begin
                // hold here until the output register can take the result
                if (i_sts.out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

### src/kvt_datapath.sv
`default_nettype none

module kvt_datapath #(
    parameter int CAPACITY   = kvt_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = kvt_pkg::WORD_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  kvt_pkg::t_ctl                    i_ctl,
    output kvt_pkg::t_sts                    o_sts,
    input  wire  [1:0]                       i_command,
    input  wire  [WORD_WIDTH-1:0]            i_key,
    input  wire  [WORD_WIDTH-1:0]            i_value,
    input  wire                              i_stall,
    output logic                             o_valid,
    output logic                             o_found,
    output logic [kvt_pkg::VALUE_OUT_W-1:0]  o_value_out,
    output logic [kvt_pkg::COUNT_OUT_W-1:0]  o_entry_count,
    output logic [kvt_pkg::STATUS_W-1:0]     o_status
);

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int VAL_O_W = kvt_pkg::VALUE_OUT_W;
    localparam int CNT_O_W = kvt_pkg::COUNT_OUT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    // slot stores
    logic [WORD_WIDTH-1:0] key_mem [CAPACITY];
    logic [WORD_WIDTH-1:0] val_mem [CAPACITY];
    logic                  vld_mem [CAPACITY];

    // captured request
    kvt_pkg::t_cmd         r_cmd;
    logic [WORD_WIDTH-1:0] r_key;
    logic [WORD_WIDTH-1:0] r_val;

    // scan state
    logic [IDX_W-1:0]      r_idx;
    logic                  r_issue_done;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic [WORD_WIDTH-1:0] r_rd_key;
    logic                  r_rd_vld;
    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic                  r_free;
    logic [IDX_W-1:0]      r_free_idx;
    logic [WORD_WIDTH-1:0] r_rd_val;

    logic [IDX_W-1:0]      r_clr_idx;
    logic [CNT_W-1:0]      r_count;

    logic                  r_out_valid;
    logic                  r_out_found;
    logic [VAL_O_W-1:0]    r_out_value;
    logic [CNT_O_W-1:0]    r_out_count;
    kvt_pkg::t_status      r_out_status;

    logic                  ins_en;
    logic                  upd_en;
    logic                  del_en;
    logic                  vld_we;
    logic [IDX_W-1:0]      vld_wa;
    logic                  vld_wd;
    kvt_pkg::t_status      n_status;

    assign ins_en = i_ctl.act && (r_cmd == kvt_pkg::CMD_PUT) && !r_hit && r_free;
    assign upd_en = i_ctl.act && (r_cmd == kvt_pkg::CMD_PUT) && r_hit;
    assign del_en = i_ctl.act && (r_cmd == kvt_pkg::CMD_DELETE) && r_hit;

    always_comb begin
        vld_we = 1'b0;
        vld_wa = r_clr_idx;
        vld_wd = 1'b0;
        if (i_ctl.clear) begin
            vld_we = 1'b1;
        end else if (ins_en) begin
            vld_we = 1'b1;
            vld_wa = r_free_idx;
            vld_wd = 1'b1;
        end else if (del_en) begin
            vld_we = 1'b1;
            vld_wa = r_hit_idx;
        end
    end

    // memories: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (ins_en) begin
            key_mem[r_free_idx] <= r_key;
        end
        r_rd_key <= key_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (ins_en || upd_en) begin
            val_mem[upd_en ? r_hit_idx : r_free_idx] <= r_val;
        end
        r_rd_val <= val_mem[r_hit_idx];
    end

    always_ff @(posedge i_clk) begin
        if (vld_we) begin
            vld_mem[vld_wa] <= vld_wd;
        end
        r_rd_vld <= vld_mem[r_idx];
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= kvt_pkg::t_cmd'(i_command);
            r_key <= i_key;
            r_val <= i_value;
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_cmp_idx    <= '0;
            r_hit        <= 1'b0;
            r_hit_idx    <= '0;
            r_free       <= 1'b0;
            r_free_idx   <= '0;
        end else if (i_ctl.load) begin
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_free       <= 1'b0;
        end else if (i_ctl.scan) begin
            r_cmp_vld <= !r_issue_done;
            r_cmp_idx <= r_idx;
            if (!r_issue_done) begin
                if (r_idx == LAST_IDX) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (r_cmp_vld) begin
                if (r_rd_vld && (r_rd_key == r_key) && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                end
                if (!r_rd_vld && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_cmp_idx;
                end
            end
        end
    end

    // clear sweep and live count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_count   <= '0;
        end else begin
            if (i_ctl.clear && (r_clr_idx != LAST_IDX)) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (ins_en) begin
                r_count <= r_count + 1'b1;
            end else if (del_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_comb begin
        n_status = kvt_pkg::ST_OK;
        if ((r_cmd == kvt_pkg::CMD_PUT) && !r_hit && !r_free) begin
            n_status = kvt_pkg::ST_FULL;
        end else if ((r_cmd == kvt_pkg::CMD_GET) && !r_hit) begin
            n_status = kvt_pkg::ST_ABSENT;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_out_found  <= r_hit;
            r_out_value  <= ((r_cmd == kvt_pkg::CMD_GET) && r_hit) ?
                            VAL_O_W'(r_rd_val) : '0;
            r_out_count  <= CNT_O_W'(r_count);
            r_out_status <= n_status;
        end
    end

    assign o_sts.clear_last = i_ctl.clear && (r_clr_idx == LAST_IDX);
    assign o_sts.scan_last  = r_cmp_vld && (r_cmp_idx == LAST_IDX);
    assign o_sts.out_free   = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_value_out   = r_out_value;
    assign o_entry_count = r_out_count;
    assign o_status      = r_out_status;

endmodule

`default_nettype wire
